// ===== rtl/idll_pkg.sv =====
// Package for the indexed doubly linked list unit: field widths, opcodes,
// status codes, controller states and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package idll_pkg;

  localparam int IDLL_CAPACITY = 1024;

  localparam int OPCODE_W = 3;
  localparam int IDX_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int LINK_W   = 11;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD       = 3'd0,
    OP_BEGIN      = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_WALK       = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_END    = 2'd2,
    STS_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_WALK,
    S_FIN
  } state_t;

  // memory read source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_PORT,
    RD_WALK
  } rd_sel_t;

  // memory write step
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_STEP1,
    WR_FINAL
  } wr_sel_t;

  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    logic    capture;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic    clr_last;
    opcode_t port_op;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_doubly_linked_list_unit.sv =====
// The result register loads in the final state; load, begin, remove and unused
// opcodes go there from the accepting edge, insert and walk step pass an extra
// state first (extra link write or read); a held result keeps the final state
// while out_ready stays low. A new item is taken only after the last one loads
// its result, set by the registered read and single write port of the link
// memories; one item is in flight at a time. Reset: a clearing pass writes zero
// to all CAPACITY+1 link entries with in_ready low; value memory is not cleared.
`default_nettype none

module indexed_doubly_linked_list_unit #(
  parameter int CAPACITY = idll_pkg::IDLL_CAPACITY
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic        [idll_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic        [idll_pkg::IDX_W-1:0]    in_node_index,
  input  wire logic signed [idll_pkg::VALUE_W-1:0]  in_value,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_next_link,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_prev_link,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_first_node,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_last_node,
  input  wire logic        [idll_pkg::CNT_W-1:0]    in_node_count,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [idll_pkg::STATUS_W-1:0] out_status,
  output logic             [idll_pkg::IDX_W-1:0]    out_new_index,
  output logic signed      [idll_pkg::VALUE_W-1:0]  out_data_out,
  output logic                                      out_last
);

  idll_pkg::dp_cmd_t  cmd;
  idll_pkg::dp_stat_t stat;

  idll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  idll_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_opcode),
    .in_node_index (in_node_index),
    .in_value      (in_value),
    .in_next_link  (in_next_link),
    .in_prev_link  (in_prev_link),
    .in_first_node (in_first_node),
    .in_last_node  (in_last_node),
    .in_node_count (in_node_count),
    .out_status    (out_status),
    .out_new_index (out_new_index),
    .out_data_out  (out_data_out),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/idll_ctrl.sv =====
// Controller for the linked list unit: sequences clear pass, reads, write
// steps and result loading. Depends on idll_pkg.
`default_nettype none

module idll_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire idll_pkg::dp_stat_t stat,
  output idll_pkg::dp_cmd_t       cmd
);

  idll_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == idll_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idll_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      idll_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = idll_pkg::S_IDLE;
      end
      idll_pkg::S_IDLE: begin
        if (in_valid) begin
          case (stat.port_op)
            idll_pkg::OP_INS_AFTER,
            idll_pkg::OP_INS_BEFORE: state_nxt = idll_pkg::S_INS;
            idll_pkg::OP_WALK:       state_nxt = idll_pkg::S_WALK;
            default:                 state_nxt = idll_pkg::S_FIN;
          endcase
        end
      end
      idll_pkg::S_INS:  state_nxt = idll_pkg::S_FIN;
      idll_pkg::S_WALK: state_nxt = idll_pkg::S_FIN;
      idll_pkg::S_FIN: begin
        if (out_free) state_nxt = idll_pkg::S_IDLE;
      end
      default: state_nxt = idll_pkg::S_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.rd       = idll_pkg::RD_NONE;
    cmd.wr       = idll_pkg::WR_NONE;
    cmd.capture  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      idll_pkg::S_CLEAR: cmd.wr = idll_pkg::WR_CLEAR;
      idll_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.rd      = idll_pkg::RD_PORT;
        end
      end
      idll_pkg::S_INS:  cmd.wr = idll_pkg::WR_STEP1;
      idll_pkg::S_WALK: cmd.rd = idll_pkg::RD_WALK;
      idll_pkg::S_FIN: begin
        if (out_free) begin
          cmd.wr       = idll_pkg::WR_FINAL;
          cmd.out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while a result is pending");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == idll_pkg::S_INS ||
                                state_r == idll_pkg::S_WALK ||
                                state_r == idll_pkg::S_FIN))
    else $error("accepted item did not enter execution");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != idll_pkg::S_CLEAR) |=> (state_r != idll_pkg::S_CLEAR))
    else $error("clear pass re-entered without reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/idll_dpath.sv =====
// Datapath for the linked list unit: value/next/prev memories, list
// registers, captured item and result register. Depends on idll_pkg.
`default_nettype none

module idll_dpath #(
  parameter int CAPACITY = idll_pkg::IDLL_CAPACITY
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire idll_pkg::dp_cmd_t                    cmd,
  output idll_pkg::dp_stat_t                        stat,
  input  wire logic        [idll_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic        [idll_pkg::IDX_W-1:0]    in_node_index,
  input  wire logic signed [idll_pkg::VALUE_W-1:0]  in_value,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_next_link,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_prev_link,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_first_node,
  input  wire logic signed [idll_pkg::LINK_W-1:0]   in_last_node,
  input  wire logic        [idll_pkg::CNT_W-1:0]    in_node_count,
  output logic             [idll_pkg::STATUS_W-1:0] out_status,
  output logic             [idll_pkg::IDX_W-1:0]    out_new_index,
  output logic signed      [idll_pkg::VALUE_W-1:0]  out_data_out,
  output logic                                      out_last
);

  localparam int DEPTH = CAPACITY + 1;
  localparam int EW    = $clog2(DEPTH);
  localparam int VW    = idll_pkg::VALUE_W;

  typedef logic [EW-1:0] entry_t;

  // entry 0 is the sentinel, node k lives in entry k+1
  function automatic entry_t link_to_entry(input logic [idll_pkg::LINK_W-1:0] raw);
    entry_t e;
    if (raw[idll_pkg::LINK_W-1]) begin
      e = '0;
    end else if (32'(raw[idll_pkg::LINK_W-2:0]) >= CAPACITY) begin
      e = '0;
    end else begin
      e = EW'(32'(raw[idll_pkg::LINK_W-2:0]) + 32'd1);
    end
    return e;
  endfunction

  function automatic entry_t safe_entry(input entry_t e);
    return (32'(e) <= CAPACITY) ? e : '0;
  endfunction

  logic [VW-1:0] value_mem [DEPTH];
  entry_t        next_mem  [DEPTH];
  entry_t        prev_mem  [DEPTH];

  logic [VW-1:0] value_rd_r;
  entry_t        next_rd_r, prev_rd_r;

  // captured item
  idll_pkg::opcode_t          op_r;
  logic [idll_pkg::IDX_W-1:0] idx_r;
  logic [VW-1:0]              val_r;
  entry_t                     a_r, nlink_r, plink_r, first_r, last_r, cnt_r, c_r;

  // list state
  entry_t used_r, used_nxt;
  entry_t cursor_r, cursor_nxt;
  logic   active_r, active_nxt;
  entry_t clr_cnt_r, clr_cnt_nxt;

  logic [idll_pkg::STATUS_W-1:0] status_nxt;
  logic [idll_pkg::IDX_W-1:0]    new_index_nxt;
  logic [VW-1:0]                 data_nxt;
  logic                          last_nxt;

  idll_pkg::opcode_t port_op;
  entry_t            port_a, walk_a, rd_addr, cnt_sat;
  entry_t            n_e, t_e, p_e, x_e, c_e;
  logic              full, unused, load_bad, ins_err;
  logic              rd_en;

  logic          vl_we, nx_we, pv_we;
  entry_t        vl_wa, nx_wa, pv_wa, nx_wd, pv_wd;

  assign port_op = idll_pkg::opcode_t'(in_opcode);
  assign port_a  = (32'(in_node_index) < CAPACITY) ? EW'(32'(in_node_index) + 32'd1) : '0;
  assign walk_a  = active_r ? safe_entry(cursor_r) : '0;
  assign cnt_sat = (32'(in_node_count) > CAPACITY) ? EW'(CAPACITY) : EW'(in_node_count);

  assign full     = (32'(used_r) >= CAPACITY);
  assign unused   = (32'(idx_r) >= 32'(used_r));
  assign load_bad = (32'(idx_r) >= CAPACITY);
  assign ins_err  = full || unused;
  assign n_e      = used_r + EW'(1);
  assign t_e      = safe_entry((op_r == idll_pkg::OP_INS_AFTER) ? next_rd_r : prev_rd_r);
  assign p_e      = safe_entry(prev_rd_r);
  assign x_e      = safe_entry(next_rd_r);
  assign c_e      = safe_entry(next_rd_r);

  assign stat.clr_last = (clr_cnt_r == EW'(CAPACITY));
  assign stat.port_op  = port_op;

  assign rd_en   = (cmd.rd != idll_pkg::RD_NONE);
  assign rd_addr = (cmd.rd == idll_pkg::RD_WALK) ? c_e :
                   (port_op == idll_pkg::OP_WALK) ? walk_a : port_a;

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (vl_we) value_mem[vl_wa] <= val_r;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (rd_en) begin
      value_rd_r <= value_mem[rd_addr];
      next_rd_r  <= next_mem[rd_addr];
      prev_rd_r  <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= port_op;
      idx_r   <= in_node_index;
      val_r   <= in_value;
      a_r     <= port_a;
      nlink_r <= link_to_entry(in_next_link);
      plink_r <= link_to_entry(in_prev_link);
      first_r <= link_to_entry(in_first_node);
      last_r  <= link_to_entry(in_last_node);
      cnt_r   <= cnt_sat;
    end
    if (cmd.rd == idll_pkg::RD_WALK) c_r <= c_e;
    if (cmd.out_load) begin
      out_status    <= status_nxt;
      out_new_index <= new_index_nxt;
      out_data_out  <= data_nxt;
      out_last      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      cursor_r  <= '0;
      active_r  <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      used_r    <= used_nxt;
      cursor_r  <= cursor_nxt;
      active_r  <= active_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // memory writes and list state updates
  always_comb begin
    vl_we       = 1'b0;
    vl_wa       = '0;
    nx_we       = 1'b0;
    nx_wa       = '0;
    nx_wd       = '0;
    pv_we       = 1'b0;
    pv_wa       = '0;
    pv_wd       = '0;
    used_nxt    = used_r;
    cursor_nxt  = cursor_r;
    active_nxt  = active_r;
    clr_cnt_nxt = clr_cnt_r;
    case (cmd.wr)
      idll_pkg::WR_CLEAR: begin
        nx_we       = 1'b1;
        nx_wa       = clr_cnt_r;
        pv_we       = 1'b1;
        pv_wa       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + EW'(1);
      end
      idll_pkg::WR_STEP1: begin
        // first half of the splice; a stale link may point at the new
        // entry, so these writes go before the ones in the final step
        if (!ins_err) begin
          vl_we = 1'b1;
          vl_wa = n_e;
          nx_we = 1'b1;
          pv_we = 1'b1;
          if (op_r == idll_pkg::OP_INS_AFTER) begin
            nx_wa = n_e;
            nx_wd = t_e;
            pv_wa = t_e;
            pv_wd = n_e;
          end else begin
            nx_wa = t_e;
            nx_wd = n_e;
            pv_wa = n_e;
            pv_wd = t_e;
          end
        end
      end
      idll_pkg::WR_FINAL: begin
        case (op_r)
          idll_pkg::OP_LOAD: begin
            if (!load_bad) begin
              vl_we = 1'b1;
              vl_wa = a_r;
              nx_we = 1'b1;
              nx_wa = a_r;
              nx_wd = nlink_r;
              pv_we = 1'b1;
              pv_wa = a_r;
              pv_wd = plink_r;
            end
          end
          idll_pkg::OP_BEGIN: begin
            nx_we      = 1'b1;
            nx_wd      = first_r;
            pv_we      = 1'b1;
            pv_wd      = last_r;
            used_nxt   = cnt_r;
            cursor_nxt = '0;
            active_nxt = 1'b0;
          end
          idll_pkg::OP_INS_AFTER: begin
            if (!ins_err) begin
              nx_we    = 1'b1;
              nx_wa    = a_r;
              nx_wd    = n_e;
              pv_we    = 1'b1;
              pv_wa    = n_e;
              pv_wd    = a_r;
              used_nxt = n_e;
            end
          end
          idll_pkg::OP_INS_BEFORE: begin
            if (!ins_err) begin
              nx_we    = 1'b1;
              nx_wa    = n_e;
              nx_wd    = a_r;
              pv_we    = 1'b1;
              pv_wa    = a_r;
              pv_wd    = n_e;
              used_nxt = n_e;
            end
          end
          idll_pkg::OP_REMOVE: begin
            if (!unused) begin
              nx_we = 1'b1;
              nx_wa = p_e;
              nx_wd = x_e;
              pv_we = 1'b1;
              pv_wa = x_e;
              pv_wd = p_e;
            end
          end
          idll_pkg::OP_WALK: begin
            cursor_nxt = c_r;
            active_nxt = (c_r != '0);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    status_nxt    = idll_pkg::STS_OK;
    new_index_nxt = '0;
    data_nxt      = '0;
    last_nxt      = 1'b0;
    case (op_r)
      idll_pkg::OP_LOAD: begin
        if (load_bad) status_nxt = idll_pkg::STS_UNUSED;
      end
      idll_pkg::OP_INS_AFTER,
      idll_pkg::OP_INS_BEFORE: begin
        if (full) begin
          status_nxt = idll_pkg::STS_FULL;
        end else if (unused) begin
          status_nxt = idll_pkg::STS_UNUSED;
        end else begin
          new_index_nxt = idll_pkg::IDX_W'(used_r);
        end
      end
      idll_pkg::OP_REMOVE: begin
        if (unused) begin
          status_nxt = idll_pkg::STS_UNUSED;
        end else begin
          data_nxt = value_rd_r;
        end
      end
      idll_pkg::OP_WALK: begin
        if (c_r == '0) begin
          status_nxt = idll_pkg::STS_END;
        end else begin
          data_nxt = value_rd_r;
          last_nxt = (safe_entry(next_rd_r) == '0);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
